// ===== rtl/core/qmr_pkg.sv =====
// ----------------------------------------------------------------------------
// qmr_pkg
// Shared types and constants for the quaternion multiply and renorm unit.
// ----------------------------------------------------------------------------
package qmr_pkg;

  localparam int QDEPTH = 2;
  localparam int IVL_W  = 7;
  localparam logic [IVL_W-1:0] IVL_RESET = 7'd97;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] b_w;
  } qmr_in_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_w;
    logic               renormalized;
    logic               norm_zero;
    logic               saturated;
  } qmr_out_t;

  // one queued request with its renorm decision
  typedef struct packed {
    qmr_in_t op;
    logic    renorm;
  } qmr_job_t;

  // one product term: component indexes of a and b, and its sign
  typedef struct packed {
    logic [1:0] ai;
    logic [1:0] bi;
    logic       neg;
  } qmr_term_t;

  localparam logic [1:0] IX = 2'd0;
  localparam logic [1:0] IY = 2'd1;
  localparam logic [1:0] IZ = 2'd2;
  localparam logic [1:0] IW = 2'd3;

  // term table, step = {component, term}
  function automatic qmr_term_t term_of(input logic [3:0] step);
    qmr_term_t t;
    case (step)
      4'd0:  t = '{IX, IW, 1'b0};
      4'd1:  t = '{IW, IX, 1'b0};
      4'd2:  t = '{IZ, IY, 1'b0};
      4'd3:  t = '{IY, IZ, 1'b1};
      4'd4:  t = '{IY, IW, 1'b0};
      4'd5:  t = '{IW, IY, 1'b0};
      4'd6:  t = '{IX, IZ, 1'b0};
      4'd7:  t = '{IZ, IX, 1'b1};
      4'd8:  t = '{IZ, IW, 1'b0};
      4'd9:  t = '{IW, IZ, 1'b0};
      4'd10: t = '{IY, IX, 1'b0};
      4'd11: t = '{IX, IY, 1'b1};
      4'd12: t = '{IW, IW, 1'b0};
      4'd13: t = '{IX, IX, 1'b1};
      4'd14: t = '{IY, IY, 1'b1};
      4'd15: t = '{IZ, IZ, 1'b1};
      default: t = '{IX, IX, 1'b0};
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/qmr_front.sv =====
// ----------------------------------------------------------------------------
// qmr_front
// Accepts requests, keeps the call counter and interval register, and tags
// each request with its renorm decision before it enters the queue.
// ----------------------------------------------------------------------------
module qmr_front import qmr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  qmr_in_t           in_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IVL_W-1:0]  cfg_data,
  output logic              push,
  output qmr_job_t          push_job
);

  logic [IVL_W-1:0] interval;
  logic [IVL_W-1:0] call_count;
  logic [IVL_W:0]   count_next;
  logic             due;

  assign cfg_ready  = 1'b1;
  assign count_next = {1'b0, call_count} + {{IVL_W{1'b0}}, 1'b1};
  assign due        = count_next > {1'b0, interval};
  assign push       = in_valid && in_ready;
  assign push_job   = '{op: in_data, renorm: due};

  // interval register
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= IVL_RESET;
    end else if (cfg_valid) begin
      interval <= cfg_data;
    end
  end

  // call counter
  always_ff @(posedge clk) begin
    if (rst) begin
      call_count <= '0;
    end else if (push) begin
      call_count <= due ? '0 : count_next[IVL_W-1:0];
    end
  end

endmodule

// ===== rtl/core/qmr_queue.sv =====
// ----------------------------------------------------------------------------
// qmr_queue
// Short request queue between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
module qmr_queue import qmr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  qmr_job_t                      push_job,
  input  logic                          pop,
  output logic                          head_valid,
  output qmr_job_t                      head_job,
  output logic [$clog2(QDEPTH+1)-1:0]   level
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(QDEPTH - 1);

  qmr_job_t mem [QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;

  assign head_valid = level != '0;
  assign head_job   = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/qmr_back.sv =====
// ----------------------------------------------------------------------------
// qmr_back
// Sequential arithmetic: sixteen products on one multiplier, rounding and
// saturation, squared norm, bit-serial division, and the output register.
// ----------------------------------------------------------------------------
module qmr_back import qmr_pkg::*; #(
  parameter int FRAC_BITS = 29
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  input  qmr_job_t  job_in,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output qmr_out_t  out_data
);

  // rounded squared norm is at most 2^(64-FRAC_BITS)
  localparam int MW = 65 - FRAC_BITS;
  localparam int NW = (33 + FRAC_BITS > MW + 1) ? 33 + FRAC_BITS : MW + 1;
  localparam int DW = $clog2(NW + 1);
  localparam logic signed [65:0] HALF  = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] S_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S_MIN = -66'sd2147483648;
  localparam logic [NW-1:0] NEG_LIM = NW'(64'h8000_0000);
  localparam logic [NW-1:0] POS_LIM = NW'(64'h7fff_ffff);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_RND  = 4'd2;
  localparam logic [3:0] S_NORM = 4'd3;
  localparam logic [3:0] S_NRND = 4'd4;
  localparam logic [3:0] S_DSET = 4'd5;
  localparam logic [3:0] S_DIT  = 4'd6;
  localparam logic [3:0] S_DFIN = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]         state;
  qmr_job_t           job;
  logic [1:0]         comp;
  logic [2:0]         cnt;
  logic signed [63:0] preg;
  logic               pneg;
  logic signed [65:0] acc;
  logic signed [31:0] r [4];
  logic               sat;
  logic               zero;
  logic               done_renorm;
  logic [MW-1:0]      mag;
  logic [NW-1:0]      num;
  logic [NW-1:0]      quo;
  logic [MW-1:0]      rem;
  logic [DW-1:0]      dcnt;
  logic               rneg;

  qmr_term_t          term;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic [1:0]         rsel;
  logic signed [31:0] rsrc;
  logic signed [65:0] pext;
  logic signed [65:0] rsum;
  logic signed [65:0] rsh;
  logic [32:0]        rabs;
  logic [MW:0]        rem_s;
  logic               ge;

  function automatic logic signed [31:0] pick(input qmr_job_t j, input logic [1:0] i,
                                              input logic sel_b);
    logic signed [31:0] v;
    case (i)
      IX:      v = sel_b ? j.op.b_x : j.op.a_x;
      IY:      v = sel_b ? j.op.b_y : j.op.a_y;
      IZ:      v = sel_b ? j.op.b_z : j.op.a_z;
      default: v = sel_b ? j.op.b_w : j.op.a_w;
    endcase
    return v;
  endfunction

  // operand and term selection
  assign term  = term_of({comp, cnt[1:0]});
  assign opa   = pick(job, term.ai, 1'b0);
  assign opb   = pick(job, term.bi, 1'b1);
  assign rsel  = (state == S_NORM) ? cnt[1:0] : comp;
  assign rsrc  = r[rsel];
  assign pext  = {{2{preg[63]}}, preg};
  assign rsum  = acc + HALF;
  assign rsh   = rsum >>> FRAC_BITS;
  assign rabs  = rsrc[31] ? 33'(-{rsrc[31], rsrc}) : {1'b0, rsrc};
  assign rem_s = {rem, num[NW-1]};
  assign ge    = rem_s >= {1'b0, mag};
  assign pop   = (state == S_IDLE) && job_valid;

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            job         <= job_in;
            comp        <= 2'd0;
            cnt         <= 3'd0;
            sat         <= 1'b0;
            zero        <= 1'b0;
            done_renorm <= 1'b0;
            state       <= S_MUL;
          end
        end
        // one product per cycle, accumulated in the next cycle
        S_MUL, S_NORM: begin
          if (cnt < 3'd4) begin
            if (state == S_MUL) begin
              preg <= opa * opb;
              pneg <= term.neg;
            end else begin
              preg <= rsrc * rsrc;
              pneg <= 1'b0;
            end
          end
          if (cnt != 3'd0) begin
            acc <= ((cnt == 3'd1) ? 66'sd0 : acc) + (pneg ? -pext : pext);
          end
          if (cnt == 3'd4) begin
            cnt   <= 3'd0;
            state <= (state == S_MUL) ? S_RND : S_NRND;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        // round half up and clip one component
        S_RND: begin
          if (rsh > S_MAX) begin
            r[comp] <= 32'sh7fff_ffff;
            sat     <= 1'b1;
          end else if (rsh < S_MIN) begin
            r[comp] <= 32'sh8000_0000;
            sat     <= 1'b1;
          end else begin
            r[comp] <= rsh[31:0];
          end
          comp <= comp + 2'd1;
          if (comp == IW) begin
            state <= job.renorm ? S_NORM : S_OUT;
          end else begin
            state <= S_MUL;
          end
        end
        // rounded squared norm
        S_NRND: begin
          mag  <= rsh[MW-1:0];
          comp <= 2'd0;
          if (rsh[MW-1:0] == '0) begin
            zero  <= 1'b1;
            state <= S_OUT;
          end else begin
            done_renorm <= 1'b1;
            state       <= S_DSET;
          end
        end
        // dividend with rounding bias
        S_DSET: begin
          rneg  <= rsrc[31];
          num   <= (NW'(rabs) << FRAC_BITS) + NW'(mag >> 1);
          rem   <= '0;
          quo   <= '0;
          dcnt  <= '0;
          state <= S_DIT;
        end
        // restoring division, one quotient bit per cycle
        S_DIT: begin
          rem  <= ge ? MW'(rem_s - {1'b0, mag}) : rem_s[MW-1:0];
          num  <= num << 1;
          quo  <= {quo[NW-2:0], ge};
          dcnt <= dcnt + 1'b1;
          if (dcnt == DW'(NW - 1)) begin
            state <= S_DFIN;
          end
        end
        // apply sign and clip
        S_DFIN: begin
          if (rneg) begin
            if (quo > NEG_LIM) begin
              r[comp] <= 32'sh8000_0000;
              sat     <= 1'b1;
            end else begin
              r[comp] <= 32'(-quo[31:0]);
            end
          end else begin
            if (quo > POS_LIM) begin
              r[comp] <= 32'sh7fff_ffff;
              sat     <= 1'b1;
            end else begin
              r[comp] <= quo[31:0];
            end
          end
          comp  <= comp + 2'd1;
          state <= (comp == IW) ? S_OUT : S_DSET;
        end
        // hand the result to the output register
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= '{r_x: r[0], r_y: r[1], r_z: r[2], r_w: r[3],
                           renormalized: done_renorm, norm_zero: zero,
                           saturated: sat};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/quaternion_multiply_renorm_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_multiply_renorm_unit
// Quaternion product with periodic division by the squared norm.
// ----------------------------------------------------------------------------
// Requests (a, b, signed fixed point) enter on in_valid/in_ready; results
// leave on out_valid/out_ready. cfg_valid/cfg_data writes the renorm
// interval; cfg_ready is always high.
// The front takes a request whenever the two-entry queue has room and
// decides there whether this request renormalizes.
// The back end uses one 32x32 multiplier for the sixteen products with
// rounding, loads a request from the queue and hands its result off, and
// finishes one request before it takes the next. A renormalizing request
// adds the squared norm and a bit-serial divider pass per component.
// Reset clears the counter to zero, the interval to 97, and empties the
// queue. A stalled receiver holds the output register; the back end then
// waits, the queue fills, and in_ready drops.
// ----------------------------------------------------------------------------
module quaternion_multiply_renorm_unit import qmr_pkg::*; #(
  parameter int FRAC_BITS = 29
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  qmr_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output qmr_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IVL_W-1:0] cfg_data
);

  logic                        push;
  qmr_job_t                    push_job;
  logic                        pop;
  logic                        head_valid;
  qmr_job_t                    head_job;
  logic [$clog2(QDEPTH+1)-1:0] level;

  assign in_ready = level != ($clog2(QDEPTH+1))'(QDEPTH);

  qmr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_job  (push_job)
  );

  qmr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .level      (level)
  );

  qmr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job_in    (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    level <= ($clog2(QDEPTH+1))'(QDEPTH))
    else $error("queue level above depth");

  // no pop from an empty queue
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");

  // a zero norm result is never marked renormalized
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.norm_zero |-> !out_data.renormalized)
    else $error("norm_zero and renormalized both set");

  // a renormalizing request clears the counter
  assert property (@(posedge clk) disable iff (rst)
    push && push_job.renorm |=> (u_front.call_count == '0))
    else $error("counter not cleared after renorm");

endmodule

// ===== dv/tb_quaternion_multiply_renorm_unit.sv =====
// ----------------------------------------------------------------------------
// tb_quaternion_multiply_renorm_unit
// Self-checking bench for the quaternion multiply and renorm unit: a directed
// table of operand extremes and renorm corner cases, then random quaternions
// under several interval settings, every result checked against a predictor.
// ----------------------------------------------------------------------------
module tb_quaternion_multiply_renorm_unit;
  import qmr_pkg::*;

  localparam int FRAC = 29;
  localparam int N_RANDOM = 1200;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  qmr_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  qmr_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IVL_W-1:0] cfg_data = '0;

  // predictor state
  logic [IVL_W-1:0] interval_m;
  logic [IVL_W-1:0] count_m;

  qmr_out_t expected_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int renorms_seen = 0;
  int zero_norms_seen = 0;
  int sats_seen = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  bit stimulus_done = 1'b0;
  bit hold_off = 1'b0;

  // directed rows: operands, whether a typed-in result applies, that result
  typedef struct {
    qmr_in_t  op;
    bit       fixed;
    qmr_out_t res;
  } row_t;

  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC;
  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  quaternion_multiply_renorm_unit #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // rounded sum of four exact products, then clip to 32 bits
  function automatic logic signed [31:0] round_sum(input logic signed [63:0] p0,
      input logic signed [63:0] p1, input logic signed [63:0] p2,
      input logic signed [63:0] p3, inout bit sat);
    logic signed [71:0] s;
    s = 72'(p0) + 72'(p1) + 72'(p2) + 72'(p3) + (72'sd1 <<< (FRAC - 1));
    s = s >>> FRAC;
    if (s > 72'(SMAX)) begin
      sat = 1'b1;
      return SMAX;
    end
    if (s < 72'(SMIN)) begin
      sat = 1'b1;
      return SMIN;
    end
    return s[31:0];
  endfunction

  function automatic logic signed [63:0] mul(input logic signed [31:0] a,
      input logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  // quaternion product plus counter-driven squared-norm division
  function automatic qmr_out_t compose_quat(input qmr_in_t q);
    qmr_out_t o;
    logic signed [31:0] r[4];
    bit sat;
    logic [7:0] nxt;
    logic [71:0] nsum;
    logic [71:0] mag;
    logic [95:0] m;
    logic [95:0] quo;
    sat = 1'b0;
    r[0] = round_sum(mul(q.a_x, q.b_w), mul(q.b_x, q.a_w), mul(q.b_y, q.a_z),
                     -mul(q.b_z, q.a_y), sat);
    r[1] = round_sum(mul(q.a_y, q.b_w), mul(q.b_y, q.a_w), mul(q.b_z, q.a_x),
                     -mul(q.b_x, q.a_z), sat);
    r[2] = round_sum(mul(q.a_z, q.b_w), mul(q.b_z, q.a_w), mul(q.b_x, q.a_y),
                     -mul(q.b_y, q.a_x), sat);
    r[3] = round_sum(mul(q.a_w, q.b_w), -mul(q.a_x, q.b_x), -mul(q.a_y, q.b_y),
                     -mul(q.a_z, q.b_z), sat);
    o = '0;
    nxt = {1'b0, count_m} + 8'd1;
    if (nxt > {1'b0, interval_m}) begin
      count_m = '0;
      nsum = '0;
      for (int i = 0; i < 4; i++) nsum += 72'(unsigned'(mul(r[i], r[i])));
      mag = (nsum + (72'd1 << (FRAC - 1))) >> FRAC;
      if (mag == 0) begin
        o.norm_zero = 1'b1;
      end else begin
        o.renormalized = 1'b1;
        for (int i = 0; i < 4; i++) begin
          m = r[i] < 0 ? 96'(-64'(r[i])) : 96'(64'(r[i]));
          quo = ((m << FRAC) + 96'(mag >> 1)) / 96'(mag);
          if (r[i] < 0) begin
            if (quo > 96'h8000_0000) begin
              sat = 1'b1;
              r[i] = SMIN;
            end else begin
              r[i] = -quo[31:0];
            end
          end else if (quo > 96'h7fff_ffff) begin
            sat = 1'b1;
            r[i] = SMAX;
          end else begin
            r[i] = quo[31:0];
          end
        end
      end
    end else begin
      count_m = nxt[6:0];
    end
    o.r_x = r[0];
    o.r_y = r[1];
    o.r_z = r[2];
    o.r_w = r[3];
    o.saturated = sat;
    return o;
  endfunction

  function automatic qmr_in_t quat_pair(input logic signed [31:0] v[8]);
    return '{v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
  endfunction

  // random component: mostly unit-scale, sometimes full range, extreme or tiny
  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? SMAX : SMIN;
      2: return 32'(signed'($urandom_range(0, 8)) - 4);
      default: return 32'(signed'($urandom_range(0, 2 * ONE)) - ONE);
    endcase
  endfunction

  function automatic qmr_in_t rand_request();
    logic signed [31:0] v[8];
    for (int i = 0; i < 8; i++) v[i] = rand_comp();
    return quat_pair(v);
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 300);
    return $urandom_range(1, 4);
  endfunction

  // predict at request acceptance, in order
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) expected_q.push_back(compose_quat(in_data));
  end

  // check each result against the oldest prediction
  always @(posedge clk) begin
    qmr_out_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_data.renormalized) renorms_seen++;
        if (out_data.norm_zero) zero_norms_seen++;
        if (out_data.saturated) sats_seen++;
        if (out_data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h z=%h w=%h rn=%b nz=%b sat=%b / got x=%h y=%h z=%h w=%h rn=%b nz=%b sat=%b",
              exp_r.r_x, exp_r.r_y, exp_r.r_z, exp_r.r_w, exp_r.renormalized,
              exp_r.norm_zero, exp_r.saturated, out_data.r_x, out_data.r_y,
              out_data.r_z, out_data.r_w, out_data.renormalized,
              out_data.norm_zero, out_data.saturated);
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 7) || stimulus_done;
    end
  end

  // watchdog on accepted-nothing cycles
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("watchdog expired");
      $display("simulation failed");
      $finish;
    end
  end

  // valid stays up into the next request when there is no gap
  task automatic send_request(input qmr_in_t q);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_interval(input logic [IVL_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    interval_m = v;
    count_m = '0 + count_m;
  endtask

  initial begin
    row_t rows[$];
    row_t rw;
    qmr_out_t fx;
    logic signed [31:0] v[8];
    logic [IVL_W-1:0] settings[5];
    logic [IVL_W-1:0] saved_count;

    interval_m = IVL_RESET;
    count_m = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity times identity, typed in
    v = '{0, 0, 0, ONE, 0, 0, 0, ONE};
    fx = '0; fx.r_w = ONE;
    rows.push_back('{quat_pair(v), 1'b1, fx});
    // all zero operands
    v = '{0, 0, 0, 0, 0, 0, 0, 0};
    fx = '0;
    rows.push_back('{quat_pair(v), 1'b1, fx});
    // full-scale operands, clipped
    v = '{SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX};
    rows.push_back('{quat_pair(v), 1'b0, fx});
    v = '{SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN};
    rows.push_back('{quat_pair(v), 1'b0, fx});
    v = '{SMIN, SMAX, SMIN, SMAX, SMAX, SMIN, SMAX, SMIN};
    rows.push_back('{quat_pair(v), 1'b0, fx});
    v = '{-1, -1, -1, -1, -1, -1, -1, -1};
    rows.push_back('{quat_pair(v), 1'b0, fx});
    v = '{ONE, 0, 0, 0, 0, ONE, 0, 0};
    rows.push_back('{quat_pair(v), 1'b0, fx});
    v = '{-32'sd1, 32'sh55555555, 32'shaaaaaaaa, 1, 32'sh12345678, -ONE, ONE, 2};
    rows.push_back('{quat_pair(v), 1'b0, fx});
    foreach (rows[i]) begin
      rw = rows[i];
      // typed-in rows: the expected value must match before sending
      if (rw.fixed) begin
        saved_count = count_m;
        fx = compose_quat(rw.op);
        count_m = saved_count;
        if (fx !== rw.res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row %0d: typed-in exp %h, predicted %h", i, rw.res, fx);
        end
      end
      send_request(rw.op);
    end
    drain_results();

    // interval zero: every request renormalizes, incl. tiny and zero norms
    write_interval('0);
    v = '{0, 0, 0, 1, 0, 0, 0, 1};
    send_request(quat_pair(v));
    v = '{0, 0, 0, 0, 0, 0, 0, 0};
    send_request(quat_pair(v));
    v = '{0, 0, 0, 2, 0, 0, 0, 32'sd1 <<< 14};
    send_request(quat_pair(v));
    v = '{0, 0, 0, ONE, 0, 0, 0, ONE};
    send_request(quat_pair(v));
    v = '{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE};
    send_request(quat_pair(v));

    // lowering the interval below the running count
    write_interval(7'd10);
    repeat (8) send_request(rand_request());
    write_interval(7'd2);
    repeat (3) send_request(rand_request());

    // back-pressure: receiver holds off while requests keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        repeat (6) send_request(rand_request());
        in_valid <= 1'b0;
      end
    join
    drain_results();

    settings = '{7'd1, 7'd127, 7'd5, 7'd0, 7'd97};
    foreach (settings[s]) begin
      write_interval(settings[s]);
      for (int i = 0; i < N_RANDOM / 5; i++) send_request(rand_request());
    end

    stimulus_done = 1'b1;
    drain_results();
    $display("covered %0d results: %0d renormalized, %0d zero norm, %0d clipped",
      results_seen, renorms_seen, zero_norms_seen, sats_seen);
    $display("intervals 0, 1, 2, 5, 10, 97, 127 with random stalls on both sides");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/qmr_pkg.sv
rtl/core/qmr_front.sv
rtl/core/qmr_queue.sv
rtl/core/qmr_back.sv
rtl/core/quaternion_multiply_renorm_unit.sv
dv/tb_quaternion_multiply_renorm_unit.sv
